@@ hdl/wma_pkg.sv @@
// Shared definitions for the windowed moving average block.
// Command struct between sequencer and window store, register map.
// No dependencies.
package wma_pkg;

    // register word index on the config port
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // commands from the sequencer to the window store
    typedef struct packed {
        logic clear;   // drop all held samples
        logic read;    // fetch the slot about to be overwritten
        logic update;  // store the sample, update sum, count, index
    } t_win_cmd;

endpackage

@@ hdl/wma_window.sv @@
// Sample ring memory with running sum, fill count and write index.
// Depends on wma_pkg for the command struct.
module wma_window
    import wma_pkg::*;
#(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int IDX_W       = $clog2(WINDOW_MAX),
    parameter int CNT_W       = $clog2(WINDOW_MAX + 1),
    parameter int SUM_W       = SAMPLE_BITS + CNT_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_win_cmd                      i_cmd,
    input  logic        [CNT_W-1:0]       i_window_size,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SUM_W-1:0]       o_sum,
    output logic        [CNT_W-1:0]       o_count
);

    logic        [SAMPLE_BITS-1:0] r_mem [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] r_old;
    logic signed [SUM_W-1:0]       r_sum;
    logic        [CNT_W-1:0]       r_count;
    logic        [IDX_W-1:0]       r_index;

    logic                          full;
    logic signed [SAMPLE_BITS:0]   delta;
    logic        [CNT_W-1:0]       idx_inc;

    // window full: oldest sample leaves as the new one enters
    assign full    = (r_count >= i_window_size);
    assign delta   = {i_sample[SAMPLE_BITS-1], i_sample}
                   - (full ? {r_old[SAMPLE_BITS-1], r_old} : '0);
    assign idx_inc = CNT_W'(r_index) + CNT_W'(1);

    // ring memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_old <= r_mem[r_index];
        end
        if (i_cmd.update) begin
            r_mem[r_index] <= i_sample;
        end
    end

    // sum, count and index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_sum   <= '0;
            r_count <= '0;
            r_index <= '0;
        end else if (i_cmd.update) begin
            r_sum <= r_sum + SUM_W'(delta);
            if (!full) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (idx_inc >= i_window_size) begin
                r_index <= '0;
            end else begin
                r_index <= idx_inc[IDX_W-1:0];
            end
        end
    end

    assign o_sum   = r_sum;
    assign o_count = r_count;

endmodule

@@ hdl/wma_div.sv @@
// Restoring divider, one quotient bit per cycle through one shared subtractor.
// Signed result from magnitude and sign. No package dependencies.
module wma_div #(
    parameter int DIVIDEND_W = 25,
    parameter int DIVISOR_W  = 9,
    parameter int QUOT_W     = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_W-1:0]    i_dividend,
    input  logic                     i_neg,
    input  logic [DIVISOR_W-1:0]     i_divisor,
    output logic                     o_busy,
    output logic [QUOT_W-1:0]        o_quot
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_div;
    logic                  r_neg;
    logic [STEP_W-1:0]     r_step;
    logic                  r_busy;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;
    logic [DIVIDEND_W-1:0] quot_signed;

    // shared compare/subtract
    assign trial = {r_rem, r_quot[DIVIDEND_W-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(DIVIDEND_W);
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // datapath: dividend shifts out the top as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
            r_neg  <= i_neg;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            r_quot <= {r_quot[DIVIDEND_W-2:0], ge};
        end
    end

    assign quot_signed = r_neg ? (-r_quot) : r_quot;
    assign o_quot      = quot_signed[QUOT_W-1:0];
    assign o_busy      = r_busy;

endmodule

@@ hdl/windowed_moving_average.sv @@
// Simple moving average over the last window_size signed samples. Each
// accepted sample word yields one average word: the exact running sum divided
// by the number of samples held, truncated toward zero (the divisor is the
// fill count until the window fills). After accepting a sample the block runs
// a memory read, a sum update, a divider load, the iterations of the
// bit-serial divider, which sets the pace, and the output load, which waits
// for the output register to be free, before it is ready again. The block
// takes a new sample while the previous average still waits at the output.
// Writing window_size (APB word 0) clears the window; 0 reads back as 1 and
// values above WINDOW_MAX as WINDOW_MAX. Depends on wma_pkg, wma_window, wma_div.
module windowed_moving_average
    import wma_pkg::*;
#(
    parameter int WINDOW_MAX  = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // sample in
    input  logic                          i_sample_valid,
    output logic                          o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    // average out
    output logic                          o_average_valid,
    input  logic                          i_average_ready,
    output logic signed [SAMPLE_BITS-1:0] o_average
);

    localparam int IDX_W = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_START,
        S_DIV
    } t_state;

    t_state                        r_state;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic        [CNT_W-1:0]       r_window_size;
    logic signed [SAMPLE_BITS-1:0] r_avg;
    logic                          r_avg_valid;

    t_win_cmd                      win_cmd;
    logic signed [SUM_W-1:0]       win_sum;
    logic        [CNT_W-1:0]       win_count;
    logic                          cfg_wr;
    logic                          div_start;
    logic                          div_busy;
    logic        [SUM_W-1:0]       sum_mag;
    logic        [SAMPLE_BITS-1:0] div_quot;
    logic                          out_free;
    logic                          avg_load;

    // config write decode
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
    assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? 32'(r_window_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= CNT_W'(WINDOW_MAX);
        end else if (cfg_wr) begin
            if (pwdata == '0) begin
                r_window_size <= CNT_W'(1);
            end else if (pwdata > 32'(WINDOW_MAX)) begin
                r_window_size <= CNT_W'(WINDOW_MAX);
            end else begin
                r_window_size <= pwdata[CNT_W-1:0];
            end
        end
    end

    // handshakes and commands
    assign o_sample_ready  = (r_state == S_IDLE);
    assign o_average_valid = r_avg_valid;
    assign o_average       = r_avg;
    assign out_free        = !r_avg_valid || i_average_ready;
    assign avg_load        = (r_state == S_DIV) && !div_busy && out_free;

    assign win_cmd   = '{clear: cfg_wr, read: (r_state == S_READ),
                         update: (r_state == S_UPDATE)};
    assign div_start = (r_state == S_START);
    assign sum_mag   = win_sum[SUM_W-1] ? (-win_sum) : win_sum;

    // sequencer with output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_avg_valid <= 1'b0;
        end else begin
            if (avg_load) begin
                r_avg_valid <= 1'b1;
            end else if (i_average_ready) begin
                r_avg_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_sample_valid) begin
                        r_sample <= i_sample;
                        r_state  <= S_READ;
                    end
                end
                S_READ:   r_state <= S_UPDATE;
                S_UPDATE: r_state <= S_START;
                S_START:  r_state <= S_DIV;
                S_DIV: begin
                    if (avg_load) begin
                        r_avg   <= div_quot;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    wma_window #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (win_cmd),
        .i_window_size (r_window_size),
        .i_sample      (r_sample),
        .o_sum         (win_sum),
        .o_count       (win_count)
    );

    wma_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag),
        .i_neg      (win_sum[SUM_W-1]),
        .i_divisor  (win_count),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

endmodule

@@ tb/sv/windowed_moving_average_tb.sv @@
// Self-checking testbench for windowed_moving_average: directed table, then
// random sample phases under random window sizes, with random idling on both
// channels. Depends on wma_pkg and the windowed_moving_average RTL.
module windowed_moving_average_tb;
    import wma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_MAX = 256;
    localparam int N_RANDOM = 1880;

    // byte addresses on the config port
    localparam logic [2:0] ADDR_WINDOW_SIZE = {REG_WINDOW_SIZE, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        i_sample_valid, o_sample_ready;
    logic signed [15:0] i_sample;
    logic        o_average_valid, i_average_ready;
    logic signed [15:0] o_average;

    windowed_moving_average dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_sample_valid  (i_sample_valid),
        .o_sample_ready  (o_sample_ready),
        .i_sample        (i_sample),
        .o_average_valid (o_average_valid),
        .i_average_ready (i_average_ready),
        .o_average       (o_average)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Window model: ring of samples, exact sum, fill count, write slot
    // ---------------------------------------------------------------
    logic signed [15:0] ring_mem [WIN_MAX];
    logic signed [24:0] ring_sum;
    int                 ring_fill;
    int                 ring_slot;
    int                 ring_len;

    logic signed [15:0] pending_averages [$];
    int                 averages_seen;
    int                 mismatch_count;
    bit                 tx_quiet, rx_quiet;

    function automatic logic signed [15:0] next_average(input logic signed [15:0] s);
        int quo;
        if (ring_fill >= ring_len) begin
            ring_sum = ring_sum - ring_mem[ring_slot];
        end else begin
            ring_fill++;
        end
        ring_mem[ring_slot] = s;
        ring_sum = ring_sum + s;
        ring_slot = (ring_slot + 1 >= ring_len) ? 0 : ring_slot + 1;
        // signed divide truncates toward zero
        quo = int'(ring_sum) / ring_fill;
        return quo[15:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH @%0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // ---------------------------------------------------------------
    // Average checker
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_average_valid && i_average_ready) begin
            averages_seen++;
            if (pending_averages.size() == 0) begin
                report_mismatch("average word with none expected", 32'(o_average), 'x);
            end else begin
                if (o_average !== pending_averages[0])
                    report_mismatch("average", 32'(o_average), 32'(pending_averages[0]));
                void'(pending_averages.pop_front());
            end
        end
    end

    // ---------------------------------------------------------------
    // Average receiver: random stalls, one long hold-off
    // ---------------------------------------------------------------
    initial begin : average_sink
        int  hold;
        bit  long_done;
        long_done = 1'b0;
        i_average_ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            hold = rx_quiet ? 0 : $urandom_range(0, 3);
            // long stall fills the block and backs up the sample side
            if (!long_done && averages_seen >= 600) begin
                hold = 150;
                long_done = 1'b1;
            end
            if (hold > 0) begin
                i_average_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_average_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_average_valid && i_average_ready));
        end
    end

    // ---------------------------------------------------------------
    // Sample sender
    // ---------------------------------------------------------------
    task automatic send_sample(input logic signed [15:0] s, input bit fixed,
                               input logic signed [15:0] fixed_avg);
        int gap;
        logic signed [15:0] want;
        gap = tx_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_sample_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample       <= s;
        do @(posedge i_clk); while (!(i_sample_valid && o_sample_ready));
        want = next_average(s);
        if (fixed)
            want = fixed_avg;
        pending_averages = {pending_averages, want};
    endtask

    // Drain, write a register over APB, then read window_size back.
    task automatic write_window_reg(input logic [2:0] addr, input logic [31:0] value);
        i_sample_valid <= 1'b0;
        while (pending_averages.size() != 0) @(posedge i_clk);
        // write: setup then access
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_WINDOW_SIZE) begin
            ring_len  = (value == 0) ? 1 : (value > WIN_MAX) ? WIN_MAX : int'(value);
            ring_sum  = '0;
            ring_fill = 0;
            ring_slot = 0;
        end
        // read back window_size
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WINDOW_SIZE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(ring_len))
            report_mismatch("window_size readback", prdata, 32'(ring_len));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_sample(input int mode, input bit lean_neg);
        int r;
        r = $urandom_range(0, 9);
        // extreme mode pushes the sum toward its limits
        if (mode == 0 && r < 8)
            return lean_neg ? 16'sh8000 : 16'sh7fff;
        case (r)
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2, 3:    return 16'($urandom_range(0, 16)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Directed table
    // ---------------------------------------------------------------
    typedef struct packed {
        bit                 do_cfg;
        logic [2:0]         addr;
        logic [31:0]        value;
        logic signed [15:0] sample;
        bit                 fixed;
        logic signed [15:0] avg;
    } t_step;

    localparam int N_STEPS = 21;
    localparam t_step STEPS [N_STEPS] = '{
        // reset window: a single sample averages to itself
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh7fff, 1'b1, 16'sh7fff},
        // sum of -1 over two truncates to zero
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh8000, 1'b1, 16'sh0000},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh8000, 1'b0, 16'sh0000},
        // window of one passes samples through
        '{1'b1, ADDR_WINDOW_SIZE, 32'd1,   16'sh8000, 1'b1, 16'sh8000},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh7fff, 1'b1, 16'sh7fff},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'shffff, 1'b1, 16'shffff},
        // zero window acts as one
        '{1'b1, ADDR_WINDOW_SIZE, 32'd0,   16'sh0005, 1'b1, 16'sh0005},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'shfff9, 1'b1, 16'shfff9},
        // window of two: rounding toward zero both ways
        '{1'b1, ADDR_WINDOW_SIZE, 32'd2,   16'shffff, 1'b1, 16'shffff},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh0000, 1'b1, 16'sh0000},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh0003, 1'b1, 16'sh0001},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh8000, 1'b0, 16'sh0000},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh8000, 1'b1, 16'sh8000},
        // oversize window saturates
        '{1'b1, ADDR_WINDOW_SIZE, 32'd511, 16'sh7fff, 1'b1, 16'sh7fff},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh7fff, 1'b1, 16'sh7fff},
        '{1'b1, ADDR_WINDOW_SIZE, 32'd3,   16'sh0001, 1'b0, 16'sh0000},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh0002, 1'b0, 16'sh0000},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh0004, 1'b0, 16'sh0000},
        // unmapped address is ignored, window keeps going
        '{1'b1, ADDR_UNMAPPED,    32'd1,   16'shfff8, 1'b0, 16'sh0000},
        '{1'b0, ADDR_WINDOW_SIZE, 32'd0,   16'sh0005, 1'b0, 16'sh0000},
        '{1'b1, ADDR_WINDOW_SIZE, 32'd256, 16'sh1234, 1'b1, 16'sh1234}
    };

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        int          sent, ph, n_items, mode;
        bit          lean_neg;
        logic [31:0] win_word;

        mismatch_count = 0;
        averages_seen  = 0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        ring_len       = WIN_MAX;
        ring_sum       = '0;
        ring_fill      = 0;
        ring_slot      = 0;
        i_rst_n        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        i_sample_valid <= 1'b0;
        i_sample       <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_STEPS; k++) begin
            if (STEPS[k].do_cfg)
                write_window_reg(STEPS[k].addr, STEPS[k].value);
            send_sample(STEPS[k].sample, STEPS[k].fixed, STEPS[k].avg);
        end

        // random phases, each under its own window size
        sent = 0;
        ph   = 0;
        while (sent < N_RANDOM) begin
            case (ph % 8)
                0:       win_word = 32'd256;
                1:       win_word = 32'd1;
                2:       win_word = 32'd0;
                3:       win_word = 32'd2;
                4:       win_word = $urandom_range(3, 16);
                5:       win_word = $urandom_range(17, 255);
                6:       win_word = $urandom_range(257, 511);
                default: win_word = $urandom_range(1, 256);
            endcase
            write_window_reg(ADDR_WINDOW_SIZE, win_word);
            n_items  = (ring_len >= 128) ? $urandom_range(300, 400) : $urandom_range(60, 160);
            if (n_items > N_RANDOM - sent)
                n_items = N_RANDOM - sent;
            mode     = $urandom_range(0, 3);
            lean_neg = $urandom_range(0, 1);
            tx_quiet = (ph % 3 == 1);
            rx_quiet = (ph % 4 == 2);
            for (int k = 0; k < n_items; k++)
                send_sample(pick_sample(mode, lean_neg), 1'b0, 16'sh0000);
            sent += n_items;
            ph++;
        end

        // drain, then watch for stray words
        i_sample_valid <= 1'b0;
        for (int k = 0; k < 5000 && pending_averages.size() != 0; k++)
            @(posedge i_clk);
        if (pending_averages.size() != 0)
            report_mismatch("averages never produced", pending_averages.size(), 0);
        repeat (40) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // run limit
    initial begin : watchdog
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
